FILE: design/jkh_pkg.sv
// shared types, constants and the mix round step for the lookup2 byte-key hasher
package jkh_pkg;

  localparam logic [31:0] GOLDEN_RATIO = 32'h9e3779b9;
  localparam int unsigned GROUP_BYTES  = 12;
  localparam int unsigned MIX_STEPS    = 9;

  localparam logic [1:0] TGT_A = 2'd0;
  localparam logic [1:0] TGT_B = 2'd1;
  localparam logic [1:0] TGT_C = 2'd2;

  localparam logic [4:0] MIX_SHIFT [MIX_STEPS] = '{
    5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
  };

  localparam logic [1:0] MIX_TARGET [MIX_STEPS] = '{
    TGT_A, TGT_B, TGT_C, TGT_A, TGT_B, TGT_C, TGT_A, TGT_B, TGT_C
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  typedef struct packed {
    logic final_job;
    abc_t w;
  } job_t;

  typedef struct packed {
    logic in_key;
    logic busy;
    logic pend;
  } col_status_t;

  function automatic abc_t mix_step(abc_t x, logic [3:0] k);
    abc_t       r;
    logic [4:0] sh;
    r  = x;
    sh = MIX_SHIFT[k];
    case (MIX_TARGET[k])
      TGT_A: begin
        r.a = (x.a - x.b - x.c) ^ (x.c >> sh);
      end
      TGT_B: begin
        r.b = (x.b - x.c - x.a) ^ (x.a << sh);
      end
      TGT_C: begin
        r.c = (x.c - x.a - x.b) ^ (x.b >> sh);
      end
      default: begin
        r = x;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: design/byte_key_jenkins_hash.sv
// top level: streaming lookup2 byte-key hasher with output register
// throughput: one transaction per cycle while in_stall_o is low; the input stalls after a key's
//   closing item while the key's last group mix is still in the 9-stage mix pipeline, while a
//   group is one byte short of full with a group mix in flight, and while a hash waits at a stalled output
// reset: asynchronous active low; clears seed, key state, pipeline and output valid
module byte_key_jenkins_hash import jkh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic        adv;
  logic        wb_valid;
  logic        job_valid;
  job_t        job;
  logic        end_valid;
  job_t        end_job;
  col_status_t status;
  logic        out_valid_q;
  logic [31:0] hash_q;

  assign adv      = ~(end_valid & end_job.final_job & out_valid_q & out_stall_i);
  assign wb_valid = end_valid & ~end_job.final_job & adv;

  jkh_collect u_collect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .has_byte_i  (has_byte_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .adv_i       (adv),
    .wb_valid_i  (wb_valid),
    .wb_abc_i    (end_job.w),
    .job_valid_o (job_valid),
    .job_o       (job),
    .status_o    (status)
  );

  jkh_mix_pipe u_mix_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .job_valid_i (job_valid),
    .job_i       (job),
    .end_valid_o (end_valid),
    .end_job_o   (end_job)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && end_valid && end_job.final_job) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && end_valid && end_job.final_job) begin
      hash_q <= end_job.w.c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  // group writeback only for a key with a mix in flight
  a_wb_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_valid |-> status.busy)
    else $error("group writeback without a mix in flight");

  // a waiting key end belongs to an open key
  a_pend_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pend |-> status.in_key)
    else $error("pending key end outside a key");

  // a frozen pipeline takes no input transaction
  a_freeze_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> in_stall_o)
    else $error("input taken while pipeline is frozen");

  // a group job is never issued on top of an in-flight group mix
  a_no_double_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid && !job.final_job) |-> !status.busy)
    else $error("group job issued while a group mix is in flight");

endmodule

FILE: design/jkh_mix_pipe.sv
// nine-stage pipelined mix, one round step per stage
module jkh_mix_pipe import jkh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic end_valid_o,
  output job_t end_job_o
);

  logic stg_valid_q [MIX_STEPS+1];
  job_t stg_q       [MIX_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= MIX_STEPS; i++) begin
        stg_valid_q[i] <= 1'b0;
      end
    end else if (adv_i) begin
      stg_valid_q[0] <= job_valid_i;
      for (int i = 0; i < MIX_STEPS; i++) begin
        stg_valid_q[i+1] <= stg_valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stg_q[0] <= job_i;
      for (int i = 0; i < MIX_STEPS; i++) begin
        stg_q[i+1].final_job <= stg_q[i].final_job;
        stg_q[i+1].w         <= mix_step(stg_q[i].w, 4'(i));
      end
    end
  end

  assign end_valid_o = stg_valid_q[MIX_STEPS];
  assign end_job_o   = stg_q[MIX_STEPS];

endmodule

FILE: design/jkh_collect.sv
// byte collector, key state and mix job issue
module jkh_collect import jkh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        in_stall_o,
  input  logic        adv_i,
  input  logic        wb_valid_i,
  input  abc_t        wb_abc_i,
  output logic        job_valid_o,
  output job_t        job_o,
  output col_status_t status_o
);

  logic [31:0] seed_q;
  logic        in_key_q;
  logic        busy_q;
  logic        pend_q;
  logic [3:0]  fill_q;
  logic [31:0] len_q;
  logic [7:0]  bytes_q [GROUP_BYTES];
  abc_t        st_q;

  logic        acc, eh, el, act;
  logic        fire_pend, final_now, fire_final, group;
  logic [3:0]  cnt;
  logic [31:0] len_new;
  logic [7:0]  cur [GROUP_BYTES];
  logic [7:0]  tb  [GROUP_BYTES];
  abc_t        seeds, base;
  logic [31:0] gw0, gw1, gw2, tw0, tw1, tw2;

  assign in_stall_o = pend_q | ~adv_i | (busy_q & (fill_q == 4'(GROUP_BYTES - 1)));
  assign acc        = in_valid_i & ~in_stall_o;
  assign eh         = acc & has_byte_i;
  assign el         = acc & last_i;
  assign act        = acc & (has_byte_i | last_i);
  assign fire_pend  = pend_q & ~busy_q & adv_i;

  assign cnt     = fill_q + {3'b000, eh};
  assign len_new = len_q + {31'b0, eh};
  assign group   = eh & (cnt == 4'(GROUP_BYTES));

  always_comb begin
    for (int i = 0; i < GROUP_BYTES; i++) begin
      cur[i] = (eh && (fill_q == 4'(i))) ? data_byte_i : bytes_q[i];
      tb[i]  = (4'(i) < cnt) ? cur[i] : 8'h00;
    end
  end

  assign gw0 = {cur[3], cur[2], cur[1], cur[0]};
  assign gw1 = {cur[7], cur[6], cur[5], cur[4]};
  assign gw2 = {cur[11], cur[10], cur[9], cur[8]};
  // tail bytes of the third word sit one byte up
  assign tw0 = {tb[3], tb[2], tb[1], tb[0]};
  assign tw1 = {tb[7], tb[6], tb[5], tb[4]};
  assign tw2 = {tb[10], tb[9], tb[8], 8'h00};

  assign seeds = '{a: GOLDEN_RATIO, b: GOLDEN_RATIO, c: seed_q};
  assign base  = in_key_q ? st_q : seeds;

  assign final_now  = el & ~busy_q & ~group;
  assign fire_final = final_now | fire_pend;

  assign job_valid_o = group | fire_final;

  always_comb begin
    job_o.final_job = ~group;
    if (group) begin
      job_o.w.a = base.a + gw0;
      job_o.w.b = base.b + gw1;
      job_o.w.c = base.c + gw2;
    end else begin
      job_o.w.a = base.a + tw0;
      job_o.w.b = base.b + tw1;
      job_o.w.c = base.c + tw2 + len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q   <= '0;
      in_key_q <= 1'b0;
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      fill_q   <= '0;
      len_q    <= '0;
      st_q     <= '{a: GOLDEN_RATIO, b: GOLDEN_RATIO, c: 32'h0};
    end else begin
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
      if (fire_final) begin
        in_key_q <= 1'b0;
      end else if (act) begin
        in_key_q <= 1'b1;
      end
      if (fire_pend) begin
        pend_q <= 1'b0;
      end else if (el && (busy_q || group)) begin
        pend_q <= 1'b1;
      end
      if (group) begin
        busy_q <= 1'b1;
      end else if (wb_valid_i) begin
        busy_q <= 1'b0;
      end
      if (fire_final) begin
        fill_q <= '0;
        len_q  <= '0;
      end else if (eh) begin
        fill_q <= group ? 4'd0 : cnt;
        len_q  <= len_new;
      end
      if (wb_valid_i) begin
        st_q <= wb_abc_i;
      end else if (act && !in_key_q) begin
        st_q <= seeds;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (eh) begin
      bytes_q[fill_q] <= data_byte_i;
    end
  end

  assign status_o = '{in_key: in_key_q, busy: busy_q, pend: pend_q};

endmodule

FILE: test/testbench.sv
// self-checking testbench for the streaming lookup2 byte-key hasher
`timescale 1ns / 1ps

module testbench import jkh_pkg::*;;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned PHASES       = 6;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } key_item_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] hash_value_o;

  key_item_t   pending_items[$];
  logic [31:0] expected_hashes[$];

  logic [31:0] seed_reg;
  logic [31:0] acc_a;
  logic [31:0] acc_b;
  logic [31:0] acc_c;
  logic [7:0]  grp[GROUP_BYTES];
  int unsigned grp_fill;
  logic [31:0] key_len;
  logic        key_open;

  bit          in_taken;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned hashes_checked;
  int unsigned seeds_written;

  byte_key_jenkins_hash u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .has_byte_i   (has_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic lookup2_mix(inout logic [31:0] a, inout logic [31:0] b,
                             inout logic [31:0] c);
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
  endtask

  task automatic predict_hash(key_item_t it);
    logic [31:0] byte_word;
    int unsigned i;
    if (!it.has && !it.last) return;
    if (!key_open) begin
      acc_a    = GOLDEN_RATIO;
      acc_b    = GOLDEN_RATIO;
      acc_c    = seed_reg;
      grp_fill = 0;
      key_len  = '0;
      key_open = 1'b1;
    end
    if (it.has) begin
      grp[grp_fill] = it.data;
      grp_fill++;
      key_len++;
      if (grp_fill == GROUP_BYTES) begin
        acc_a += {grp[3], grp[2], grp[1], grp[0]};
        acc_b += {grp[7], grp[6], grp[5], grp[4]};
        acc_c += {grp[11], grp[10], grp[9], grp[8]};
        lookup2_mix(acc_a, acc_b, acc_c);
        grp_fill = 0;
      end
    end
    if (!it.last) return;
    // tail bytes; c gets them one byte up since its low byte carries the length
    for (i = 0; i < grp_fill; i++) begin
      byte_word = {24'h0, grp[i]};
      if (i < 4) acc_a += byte_word << (8 * i);
      else if (i < 8) acc_b += byte_word << (8 * (i - 4));
      else acc_c += byte_word << (8 * (i - 8) + 8);
    end
    acc_c += key_len;
    lookup2_mix(acc_a, acc_b, acc_c);
    expected_hashes.push_back(acc_c);
    key_open = 1'b0;
    grp_fill = 0;
    key_len  = '0;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %08h want %08h", cycle_count, what, got, want);
    fail_count++;
  endtask

  // input side: transaction capture and driver
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_hash('{data: data_byte_i, has: has_byte_i, last: last_i});
      items_sent++;
      in_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      in_taken = 1'b0;
      if (pending_items.size() == 0 || $urandom_range(99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        key_item_t nxt;
        nxt = pending_items.pop_front();
        in_valid_i  <= 1'b1;
        data_byte_i <= nxt.data;
        has_byte_i  <= nxt.has;
        last_i      <= nxt.last;
      end
    end
  end

  // output side: monitor and stall generation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch("unexpected hash", hash_value_o, 32'h0);
      end else begin
        logic [31:0] want;
        want = expected_hashes.pop_front();
        hashes_checked++;
        if (hash_value_o !== want) report_mismatch("hash_value", hash_value_o, want);
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d hashes still due", cycle_count,
               expected_hashes.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] data, logic has, logic last);
    pending_items.push_back('{data: data, has: has, last: last});
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_items.size() != 0 || in_valid_i || expected_hashes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    seed_reg = value;
    seeds_written++;
  endtask

  // one random key; returns the number of items that count as stimulus
  task automatic push_random_key(output int unsigned counted);
    int unsigned len;
    int unsigned sel;
    int unsigned k;
    bit          closing_empty;
    counted = 0;
    sel = $urandom_range(99);
    if (sel < 8) len = 0;
    else if (sel < 18) len = 12 * $urandom_range(1, 3);
    else if (sel < 70) len = $urandom_range(1, 14);
    else if (sel < 94) len = $urandom_range(15, 40);
    else len = $urandom_range(41, 100);
    closing_empty = (len == 0) || ($urandom_range(99) < 15);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(99) < 5) begin
        push_item(8'($urandom_range(255)), 1'b0, 1'b0);
        counted++;
      end
      push_item(8'($urandom_range(255)), 1'b1, !closing_empty && (k == len - 1));
      counted++;
    end
    if (closing_empty) begin
      push_item(8'($urandom_range(255)), 1'b0, 1'b1);
      counted++;
    end
  endtask

  initial begin
    logic [31:0] phase_seed[PHASES];
    int unsigned phase;
    int unsigned counted;
    int unsigned key_items;
    int unsigned k;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    has_byte_i    = 1'b0;
    last_i        = 1'b0;
    out_stall_i   = 1'b0;
    in_taken      = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cycle_count   = 0;
    fail_count    = 0;
    items_sent    = 0;
    hashes_checked = 0;
    seeds_written = 0;
    seed_reg      = '0;
    acc_a         = GOLDEN_RATIO;
    acc_b         = GOLDEN_RATIO;
    acc_c         = '0;
    grp_fill      = 0;
    key_len       = '0;
    key_open      = 1'b0;
    foreach (grp[k]) grp[k] = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset seed, empty key, ignored item, extremes, full group
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b1);
    for (k = 0; k < GROUP_BYTES; k++) push_item(k[0] ? 8'hff : 8'h00, 1'b1,
                                                 k == GROUP_BYTES - 1);
    // key closed by an item without a byte
    push_item(8'h5a, 1'b1, 1'b0);
    push_item(8'ha5, 1'b1, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    // seed change while a key is open
    for (k = 0; k < 4; k++) push_item(8'hc3 ^ k[7:0], 1'b1, 1'b0);
    wait_drained();
    write_seed(32'hffffffff);
    push_item(8'h01, 1'b1, 1'b0);
    push_item(8'h80, 1'b1, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    wait_drained();

    phase_seed[0] = 32'h00000000;
    phase_seed[1] = $urandom;
    phase_seed[2] = 32'hffffffff;
    phase_seed[3] = GOLDEN_RATIO;
    phase_seed[4] = $urandom;
    phase_seed[5] = $urandom;

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_seed(phase_seed[phase]);
      counted = 0;
      while (counted < RANDOM_ITEMS / PHASES) begin
        push_random_key(key_items);
        counted += key_items;
      end
      // sender holds off until every due hash has come out
      wait_drained();
    end

    $display("drove %0d transactions and checked %0d hashes", items_sent, hashes_checked);
    $display("%0d seed writes across six idle/stall phases, %0d mismatches",
             seeds_written, fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
design/jkh_pkg.sv
design/jkh_mix_pipe.sv
design/jkh_collect.sv
design/byte_key_jenkins_hash.sv
test/testbench.sv
